// ----- hw/rtl/tvx_pkg.sv -----
// ----------------------------------------------------------------------------
// tvx_pkg
// Types, constants and decode helpers shared by the toy VM instruction executor.
// ----------------------------------------------------------------------------
package tvx_pkg;

   localparam int DATA_W      = 32;
   localparam int NUM_REGS    = 8;
   localparam int STACK_DEPTH = 16;
   localparam int MEM_BYTES   = 4096;  // power of two

   localparam int RIDX_W = $clog2(NUM_REGS + 1);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int SI_W   = $clog2(STACK_DEPTH);
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int DIV_CW = $clog2(DATA_W);
   localparam int NUM_GP_OUT = 8;

   // opcodes
   localparam logic [7:0] OP_MOV  = 8'h8A;
   localparam logic [7:0] OP_XCHG = 8'h86;
   localparam logic [7:0] OP_ADD  = 8'h01;
   localparam logic [7:0] OP_SUB  = 8'h2B;
   localparam logic [7:0] OP_MUL  = 8'hF6;
   localparam logic [7:0] OP_DIV  = 8'hF7;
   localparam logic [7:0] OP_AND  = 8'h21;
   localparam logic [7:0] OP_OR   = 8'h09;
   localparam logic [7:0] OP_XOR  = 8'h31;
   localparam logic [7:0] OP_PUSH = 8'h50;
   localparam logic [7:0] OP_POP  = 8'h58;
   localparam logic [7:0] OP_INC  = 8'h40;
   localparam logic [7:0] OP_DEC  = 8'h48;
   localparam logic [7:0] OP_ABS  = 8'hFA;
   localparam logic [7:0] OP_NEG  = 8'hF8;
   localparam logic [7:0] OP_NOT  = 8'hF9;

   // addressing modes
   localparam logic [3:0] MODE_REG  = 4'h0;
   localparam logic [3:0] MODE_IMM  = 4'h1;
   localparam logic [3:0] MODE_DIR  = 4'h2;
   localparam logic [3:0] MODE_IND  = 4'h3;
   localparam logic [3:0] MODE_NONE = 4'hF;

   localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ABS_MASK  = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_UNKNOWN     = 3'd1,
      ST_BAD_MODE    = 3'd2,
      ST_WRITE_IMM   = 3'd3,
      ST_STACK_EMPTY = 3'd4,
      ST_STACK_FULL  = 3'd5,
      ST_DIV_ZERO    = 3'd6,
      ST_BAD_REG     = 3'd7
   } stat_code_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_UNARY,
      KIND_BINARY
   } op_kind_type;

   typedef enum logic [1:0] {
      WS_RESULT,
      WS_V1,
      WS_V2
   } wsrc_type;

   typedef enum logic [3:0] {
      CS_CLEAR,
      CS_IDLE,
      CS_CHECK,
      CS_FETCH,
      CS_RD,
      CS_RDW,
      CS_PUSH,
      CS_POP,
      CS_POPW,
      CS_EXEC,
      CS_DIVW,
      CS_STORE,
      CS_WR,
      CS_FIN,
      CS_RSP
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0]        opcode;
      logic [7:0]        addr_mode;
      logic [DATA_W-1:0] first_operand;
      logic [DATA_W-1:0] second_operand;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [DATA_W-1:0] written_value;
      logic [DATA_W-1:0] acc_value;
      logic [DATA_W-1:0] gp0_value;
      logic [DATA_W-1:0] gp1_value;
      logic [DATA_W-1:0] gp2_value;
      logic [DATA_W-1:0] gp3_value;
      logic [DATA_W-1:0] gp4_value;
      logic [DATA_W-1:0] gp5_value;
      logic [DATA_W-1:0] gp6_value;
      logic [DATA_W-1:0] gp7_value;
   } rsp_payload_type;

   typedef struct packed {
      logic          load_item;
      logic          opsel;      // 0 destination, 1 source
      logic          ld_direct;
      logic          addr_load;
      logic          mem_rd;
      logic          mem_wr;
      logic [1:0]    byte_idx;
      logic          reg_wr;
      wsrc_type      wsrc;
      logic          alu_go;
      logic          div_start;
      logic          push;
      logic          pop;
      logic          pop_load;
      logic          finish;
      stat_code_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic          clr_busy;
      logic          err_valid;
      stat_code_type err_code;
      logic          is_push;
      logic          is_pop;
      logic          is_xchg;
      logic          is_div;
      logic          is_abs;
      logic          unary;
      logic          dst_mem;
      logic          src_mem;
      logic          dst_imm;
      logic          src_imm;
      logic          stk_full;
      logic          stk_empty;
      logic          v1_neg;
      logic          v2_zero;
      logic          div_done;
   } dp_stat_type;

   function automatic op_kind_type op_kind(input logic [7:0] op);
      op_kind_type k;
      unique case (op)
         OP_PUSH, OP_POP, OP_INC, OP_DEC, OP_ABS, OP_NEG, OP_NOT: k = KIND_UNARY;
         OP_MOV, OP_XCHG, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR:
            k = KIND_BINARY;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic is_bad_reg(input logic [3:0] mode, input logic [DATA_W-1:0] opnd);
      return ((mode == MODE_REG) || (mode == MODE_IND)) && (opnd > DATA_W'(NUM_REGS));
   endfunction

endpackage

// ----- hw/rtl/tvx_req_if.sv -----
// ----------------------------------------------------------------------------
// tvx_req_if
// Instruction channel: valid/ready handshake with a decoded instruction.
// ----------------------------------------------------------------------------
interface tvx_req_if;
   import tvx_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tvx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tvx_rsp_if
// Result channel: valid/ready handshake with status and register snapshot.
// ----------------------------------------------------------------------------
interface tvx_rsp_if;
   import tvx_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tvx_div.sv -----
// ----------------------------------------------------------------------------
// tvx_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tvx_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tvx_pkg::DATA_W-1:0] dividend,
   input  logic [tvx_pkg::DATA_W-1:0] divisor,
   output logic                      done,
   output logic [tvx_pkg::DATA_W-1:0] quotient
);
   import tvx_pkg::*;

   logic              busy_ff, done_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic [DATA_W:0]   rem_ff;
   logic [DATA_W-1:0] quo_ff, dvs_ff;
   logic [DATA_W:0]   rem_sh, diff;

   always_comb begin
      rem_sh = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_ff <= diff;
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/tvx_dpath.sv -----
// ----------------------------------------------------------------------------
// tvx_dpath
// Register file, byte memory, stack, ALU and divider, driven by the controller.
// ----------------------------------------------------------------------------
module tvx_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  tvx_pkg::req_payload_type req_payload,
   input  tvx_pkg::dp_cmd_type      cmd,
   output tvx_pkg::dp_stat_type     stat,
   output tvx_pkg::rsp_payload_type rsp_payload
);
   import tvx_pkg::*;

   req_payload_type   item_ff;
   logic [DATA_W-1:0] regs_ff [NUM_REGS+1];
   logic [DATA_W-1:0] v1_ff, v2_ff, r_ff, addr_ff, written_ff;
   stat_code_type     status_ff;
   logic [7:0]        mem [MEM_BYTES];
   logic [7:0]        mem_q_ff;
   logic              rd_pend_ff, rd_side_ff;
   logic [1:0]        rd_idx_ff;
   logic              clr_busy_ff;
   logic [MEM_AW-1:0] clr_cnt_ff;
   logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
   logic [DATA_W-1:0] stk_q_ff;
   logic [SP_W-1:0]   stk_cnt_ff;
   logic [SP_W-1:0]   stk_top;

   logic [3:0]        dm, sm, sel_mode;
   logic [DATA_W-1:0] sel_opnd, reg_q, ea, wval, alu_res;
   op_kind_type       kind;
   logic              mem_we;
   logic [MEM_AW-1:0] maddr;
   logic [7:0]        mem_wd;
   logic              div_done;
   logic [DATA_W-1:0] div_q;
   logic [DATA_W-1:0] gp_vals [NUM_GP_OUT];

   assign dm       = item_ff.addr_mode[7:4];
   assign sm       = item_ff.addr_mode[3:0];
   assign kind     = op_kind(item_ff.opcode);
   assign sel_mode = cmd.opsel ? sm : dm;
   assign sel_opnd = cmd.opsel ? item_ff.second_operand : item_ff.first_operand;
   assign reg_q    = regs_ff[sel_opnd[RIDX_W-1:0]];
   assign ea       = (sel_mode == MODE_IND) ? reg_q : sel_opnd;
   assign stk_top  = stk_cnt_ff - SP_W'(1);

   always_comb begin
      case (cmd.wsrc)
         WS_V1:   wval = v1_ff;
         WS_V2:   wval = v2_ff;
         default: wval = r_ff;
      endcase
   end

   // early checks, in priority order
   always_comb begin
      stat.err_valid = 1'b1;
      stat.err_code  = ST_OK;
      if (kind == KIND_NONE) begin
         stat.err_code = ST_UNKNOWN;
      end else if ((kind == KIND_UNARY) ? (sm != MODE_NONE || dm > MODE_IND)
                   : (dm > MODE_IND || sm > MODE_IND || (dm >= MODE_DIR && sm >= MODE_DIR)))
      begin
         stat.err_code = ST_BAD_MODE;
      end else if (is_bad_reg(dm, item_ff.first_operand) ||
                   (kind == KIND_BINARY && is_bad_reg(sm, item_ff.second_operand))) begin
         stat.err_code = ST_BAD_REG;
      end else begin
         stat.err_valid = 1'b0;
      end
   end

   always_comb begin
      stat.clr_busy  = clr_busy_ff;
      stat.is_push   = item_ff.opcode == OP_PUSH;
      stat.is_pop    = item_ff.opcode == OP_POP;
      stat.is_xchg   = item_ff.opcode == OP_XCHG;
      stat.is_div    = item_ff.opcode == OP_DIV;
      stat.is_abs    = item_ff.opcode == OP_ABS;
      stat.unary     = kind == KIND_UNARY;
      stat.dst_mem   = (dm == MODE_DIR) || (dm == MODE_IND);
      stat.src_mem   = (sm == MODE_DIR) || (sm == MODE_IND);
      stat.dst_imm   = dm == MODE_IMM;
      stat.src_imm   = sm == MODE_IMM;
      stat.stk_full  = stk_cnt_ff >= SP_W'(STACK_DEPTH);
      stat.stk_empty = stk_cnt_ff == '0;
      stat.v1_neg    = (v1_ff & SIGN_MASK) != '0;
      stat.v2_zero   = v2_ff == '0;
      stat.div_done  = div_done;
   end

   always_comb begin
      case (item_ff.opcode)
         OP_INC:  alu_res = v1_ff + 1'b1;
         OP_DEC:  alu_res = v1_ff - 1'b1;
         OP_NEG:  alu_res = '0 - v1_ff;
         OP_NOT:  alu_res = ~v1_ff;
         OP_ABS:  alu_res = ('0 - v1_ff) & ABS_MASK;
         OP_MOV:  alu_res = v2_ff;
         OP_ADD:  alu_res = v1_ff + v2_ff;
         OP_SUB:  alu_res = v1_ff - v2_ff;
         OP_MUL:  alu_res = v1_ff * v2_ff;
         OP_AND:  alu_res = v1_ff & v2_ff;
         OP_OR:   alu_res = v1_ff | v2_ff;
         default: alu_res = v1_ff ^ v2_ff;
      endcase
   end

   tvx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (v1_ff),
      .divisor  (v2_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (cmd.reg_wr) begin
         regs_ff[sel_opnd[RIDX_W-1:0]] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stk_cnt_ff <= '0;
      end else if (cmd.push) begin
         stk_cnt_ff <= stk_cnt_ff + 1'b1;
      end else if (cmd.pop) begin
         stk_cnt_ff <= stk_top;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) stk_mem[stk_cnt_ff[SI_W-1:0]] <= v1_ff;
      if (cmd.pop)  stk_q_ff <= stk_mem[stk_top[SI_W-1:0]];
   end

   // clearing pass over the byte store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == MEM_AW'(MEM_BYTES - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_comb begin
      mem_we = clr_busy_ff | cmd.mem_wr;
      maddr  = clr_busy_ff ? clr_cnt_ff : MEM_AW'(addr_ff + DATA_W'(cmd.byte_idx));
      mem_wd = clr_busy_ff ? 8'h00 : wval[8*cmd.byte_idx +: 8];
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[maddr] <= mem_wd;
      if (cmd.mem_rd) mem_q_ff <= mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.mem_rd;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= cmd.byte_idx;
      rd_side_ff <= cmd.opsel;
      if (cmd.load_item) item_ff <= req_payload;
      if (cmd.addr_load) addr_ff <= ea;
      if (cmd.ld_direct) begin
         if (cmd.opsel) v2_ff <= (sel_mode == MODE_IMM) ? sel_opnd : reg_q;
         else           v1_ff <= (sel_mode == MODE_IMM) ? sel_opnd : reg_q;
      end else if (rd_pend_ff) begin
         if (rd_side_ff) v2_ff[8*rd_idx_ff +: 8] <= mem_q_ff;
         else            v1_ff[8*rd_idx_ff +: 8] <= mem_q_ff;
      end
      if (cmd.alu_go)        r_ff <= alu_res;
      else if (div_done)     r_ff <= div_q;
      else if (cmd.pop_load) r_ff <= stk_q_ff;
      if (cmd.load_item) begin
         written_ff <= '0;
      end else if ((cmd.reg_wr || cmd.mem_wr) && !cmd.opsel) begin
         written_ff <= wval;
      end
      if (cmd.finish) status_ff <= cmd.code;
   end

   always_comb begin
      for (int k = 0; k < NUM_GP_OUT; k++) begin
         gp_vals[k] = (k < NUM_REGS) ? regs_ff[RIDX_W'(k + 1)] : '0;
      end
   end

   always_comb begin
      rsp_payload.status        = status_ff;
      rsp_payload.written_value = written_ff;
      rsp_payload.acc_value     = regs_ff[0];
      rsp_payload.gp0_value     = gp_vals[0];
      rsp_payload.gp1_value     = gp_vals[1];
      rsp_payload.gp2_value     = gp_vals[2];
      rsp_payload.gp3_value     = gp_vals[3];
      rsp_payload.gp4_value     = gp_vals[4];
      rsp_payload.gp5_value     = gp_vals[5];
      rsp_payload.gp6_value     = gp_vals[6];
      rsp_payload.gp7_value     = gp_vals[7];
   end

endmodule

// ----- hw/rtl/tvx_ctrl.sv -----
// ----------------------------------------------------------------------------
// tvx_ctrl
// Sequencer: checks, operand fetch, execute, write back and result handshake.
// ----------------------------------------------------------------------------
module tvx_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tvx_pkg::dp_stat_type stat,
   output tvx_pkg::dp_cmd_type  cmd
);
   import tvx_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           side_ff, side_in;
   logic [1:0]     cnt_ff, cnt_in;
   wsrc_type       wsrc_ff, wsrc_in;
   stat_code_type  code_ff, code_in;
   logic           side_mem;

   assign side_mem = side_ff ? stat.src_mem : stat.dst_mem;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_CLEAR;
         side_ff  <= 1'b0;
         cnt_ff   <= '0;
         wsrc_ff  <= WS_RESULT;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         cnt_ff   <= cnt_in;
         wsrc_ff  <= wsrc_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      cnt_in   = cnt_ff;
      wsrc_in  = wsrc_ff;
      code_in  = code_ff;
      unique case (state_ff)
         CS_CLEAR: if (!stat.clr_busy) state_in = CS_IDLE;
         CS_IDLE: if (req_valid) state_in = CS_CHECK;
         CS_CHECK: begin
            side_in  = 1'b0;
            state_in = CS_FETCH;
            if (stat.err_valid) begin
               code_in  = stat.err_code;
               state_in = CS_FIN;
            end else if (stat.is_push && stat.stk_full) begin
               code_in  = ST_STACK_FULL;
               state_in = CS_FIN;
            end else if (stat.is_pop) begin
               state_in = CS_POP;
               if (stat.stk_empty) begin
                  code_in  = ST_STACK_EMPTY;
                  state_in = CS_FIN;
               end else if (stat.dst_imm) begin
                  code_in  = ST_WRITE_IMM;
                  state_in = CS_FIN;
               end
            end
         end
         CS_FETCH, CS_RDW: begin
            if (state_ff == CS_FETCH && side_mem) begin
               cnt_in   = '0;
               state_in = CS_RD;
            end else if (!side_ff && !stat.unary) begin
               side_in  = 1'b1;
               state_in = CS_FETCH;
            end else if (stat.is_push) begin
               state_in = CS_PUSH;
            end else begin
               state_in = CS_EXEC;
            end
         end
         CS_RD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) state_in = CS_RDW;
         end
         CS_PUSH: begin
            code_in  = ST_OK;
            state_in = CS_FIN;
         end
         CS_POP: state_in = CS_POPW;
         CS_POPW: begin
            side_in  = 1'b0;
            wsrc_in  = WS_RESULT;
            state_in = CS_STORE;
         end
         CS_EXEC: begin
            side_in  = 1'b0;
            wsrc_in  = WS_RESULT;
            state_in = CS_STORE;
            code_in  = ST_WRITE_IMM;
            if (stat.unary) begin
               if (stat.is_abs && !stat.v1_neg) begin
                  code_in  = ST_OK;
                  state_in = CS_FIN;
               end else if (stat.dst_imm) begin
                  state_in = CS_FIN;
               end
            end else if (stat.is_xchg) begin
               wsrc_in = WS_V2;
               if (stat.dst_imm || stat.src_imm) state_in = CS_FIN;
            end else if (stat.is_div && stat.v2_zero) begin
               code_in  = ST_DIV_ZERO;
               state_in = CS_FIN;
            end else if (stat.dst_imm) begin
               state_in = CS_FIN;
            end else if (stat.is_div) begin
               state_in = CS_DIVW;
            end
         end
         CS_DIVW: if (stat.div_done) state_in = CS_STORE;
         CS_STORE, CS_WR: begin
            if (state_ff == CS_STORE && side_mem) begin
               cnt_in   = '0;
               state_in = CS_WR;
            end else if (state_ff == CS_WR && cnt_ff != 2'd3) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (stat.is_xchg && !side_ff) begin
               side_in  = 1'b1;
               wsrc_in  = WS_V1;
               state_in = CS_STORE;
            end else begin
               code_in  = ST_OK;
               state_in = CS_FIN;
            end
         end
         CS_FIN: state_in = CS_RSP;
         CS_RSP: if (rsp_ready) state_in = CS_IDLE;
         default: state_in = CS_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd        = '0;
      cmd.wsrc   = wsrc_ff;
      cmd.opsel  = side_ff;
      cmd.code   = code_ff;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         CS_FETCH: begin
            cmd.ld_direct = !side_mem;
            cmd.addr_load = side_mem;
         end
         CS_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.byte_idx = cnt_ff;
         end
         CS_PUSH:  cmd.push     = 1'b1;
         CS_POP:   cmd.pop      = 1'b1;
         CS_POPW:  cmd.pop_load = 1'b1;
         CS_EXEC: begin
            cmd.alu_go    = !stat.is_div;
            // only start the divider when its quotient will be waited for
            cmd.div_start = stat.is_div && !stat.v2_zero && !stat.dst_imm;
         end
         CS_STORE: begin
            cmd.addr_load = side_mem;
            cmd.reg_wr    = !side_mem;
         end
         CS_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.byte_idx = cnt_ff;
         end
         CS_FIN: cmd.finish = 1'b1;
         CS_RSP: rsp_valid  = 1'b1;
         default: ;
      endcase
   end

endmodule

// ----- hw/rtl/toy_vm_instruction_executor.sv -----
// Flow: checks, then operand fetch, execute and write back; memory operands are read
//   and stored one byte per cycle; xchg does a second store; divide waits for the
//   serial divider. An early error goes straight to the result.
// Throughput: one item at a time; the next item is taken after the result is taken.
// Reset: registers and stack pointer clear at once; the byte store is then cleared
//   one address at a time, during which req_chan.ready stays low.
// ----------------------------------------------------------------------------
// toy_vm_instruction_executor
// Executes one decoded toy VM instruction per item against registers, stack
// and a little-endian byte memory.
// ----------------------------------------------------------------------------
module toy_vm_instruction_executor (
   input logic      clock,
   input logic      reset,
   tvx_req_if.sink   req_chan,
   tvx_rsp_if.source rsp_chan
);
   import tvx_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   tvx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   tvx_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .cmd         (dp_cmd),
      .stat        (dp_stat),
      .rsp_payload (rsp_chan.payload)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while a result is pending");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      dp_stat.clr_busy |-> !req_chan.ready && !dp_cmd.mem_wr)
      else $error("item activity during memory clear");

   a_err_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.status != ST_OK)
      |-> rsp_chan.payload.written_value == '0)
      else $error("written value nonzero on error");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

// ----- test/tb_toy_vm_instruction_executor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_toy_vm_instruction_executor
// Drives decoded instructions into the executor with random gaps and result
// stalls, predicts status, written value and register file, and compares.
// ----------------------------------------------------------------------------
import tvx_pkg::*;

class vm_scoreboard;
   logic [31:0] acc;
   logic [31:0] gpr [NUM_REGS];
   logic [31:0] stk [STACK_DEPTH];
   int unsigned depth;
   logic [7:0] mem [MEM_BYTES];
   rsp_payload_type pending [$];
   int errors;

   function new();
      acc = 0;
      depth = 0;
      errors = 0;
      foreach (gpr[i]) gpr[i] = 0;
      foreach (stk[i]) stk[i] = 0;
      foreach (mem[i]) mem[i] = 0;
   endfunction

   function logic [31:0] rd_reg(logic [31:0] idx);
      if (idx == 0) return acc;
      if (idx <= NUM_REGS) return gpr[idx - 1];
      return 0;
   endfunction

   function void wr_reg(logic [31:0] idx, logic [31:0] v);
      if (idx == 0) acc = v;
      else if (idx <= NUM_REGS) gpr[idx - 1] = v;
   endfunction

   function logic [31:0] operand_addr(logic [3:0] m, logic [31:0] o);
      return (m == MODE_IND) ? rd_reg(o) : o;
   endfunction

   function logic [31:0] fetch(logic [3:0] m, logic [31:0] o);
      logic [31:0] a, v;
      if (m == MODE_IMM) return o;
      if (m == MODE_REG) return rd_reg(o);
      a = operand_addr(m, o);
      v = 0;
      for (int i = 0; i < 4; i++) v[8*i +: 8] = mem[(a + i) % MEM_BYTES];
      return v;
   endfunction

   function void store(logic [3:0] m, logic [31:0] o, logic [31:0] v);
      logic [31:0] a;
      if (m == MODE_REG) begin
         wr_reg(o, v);
         return;
      end
      if (m == MODE_IMM) return;
      a = operand_addr(m, o);
      for (int i = 0; i < 4; i++) mem[(a + i) % MEM_BYTES] = v[8*i +: 8];
   endfunction

   function bit reg_out_of_range(logic [3:0] m, logic [31:0] o);
      return (m == MODE_REG || m == MODE_IND) && o > NUM_REGS;
   endfunction

   function stat_code_type execute(req_payload_type q, output logic [31:0] w);
      logic [3:0] dm, sm;
      logic [31:0] v1, v2, r;
      bit unary;
      dm = q.addr_mode[7:4];
      sm = q.addr_mode[3:0];
      w = 0;
      case (q.opcode)
         OP_PUSH, OP_POP, OP_INC, OP_DEC, OP_ABS, OP_NEG, OP_NOT: unary = 1;
         OP_MOV, OP_XCHG, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR:
            unary = 0;
         default: return ST_UNKNOWN;
      endcase
      if (unary) begin
         if (sm != MODE_NONE || dm > MODE_IND) return ST_BAD_MODE;
      end else if (dm > MODE_IND || sm > MODE_IND || (dm >= MODE_DIR && sm >= MODE_DIR))
         return ST_BAD_MODE;
      if (reg_out_of_range(dm, q.first_operand) ||
          (!unary && reg_out_of_range(sm, q.second_operand))) return ST_BAD_REG;
      if (unary) begin
         if (q.opcode == OP_PUSH) begin
            if (depth >= STACK_DEPTH) return ST_STACK_FULL;
            stk[depth] = fetch(dm, q.first_operand);
            depth++;
            return ST_OK;
         end
         if (q.opcode == OP_POP) begin
            if (depth == 0) return ST_STACK_EMPTY;
            if (dm == MODE_IMM) return ST_WRITE_IMM;
            r = stk[depth - 1];
            depth--;
         end else begin
            v1 = fetch(dm, q.first_operand);
            case (q.opcode)
               OP_INC: r = v1 + 1;
               OP_DEC: r = v1 - 1;
               OP_NEG: r = -v1;
               OP_NOT: r = ~v1;
               default: begin
                  if ((v1 & SIGN_MASK) == 0) return ST_OK;
                  r = (-v1) & ABS_MASK;
               end
            endcase
            if (dm == MODE_IMM) return ST_WRITE_IMM;
         end
         store(dm, q.first_operand, r);
         w = r;
         return ST_OK;
      end
      v1 = fetch(dm, q.first_operand);
      v2 = fetch(sm, q.second_operand);
      if (q.opcode == OP_XCHG) begin
         if (dm == MODE_IMM || sm == MODE_IMM) return ST_WRITE_IMM;
         store(dm, q.first_operand, v2);
         store(sm, q.second_operand, v1);
         w = v2;
         return ST_OK;
      end
      if (q.opcode == OP_DIV && v2 == 0) return ST_DIV_ZERO;
      case (q.opcode)
         OP_MOV: r = v2;
         OP_ADD: r = v1 + v2;
         OP_SUB: r = v1 - v2;
         OP_MUL: r = v1 * v2;
         OP_DIV: r = v1 / v2;
         OP_AND: r = v1 & v2;
         OP_OR:  r = v1 | v2;
         default: r = v1 ^ v2;
      endcase
      if (dm == MODE_IMM) return ST_WRITE_IMM;
      store(dm, q.first_operand, r);
      w = r;
      return ST_OK;
   endfunction

   function void note_instruction(req_payload_type q);
      rsp_payload_type e;
      logic [31:0] w;
      stat_code_type st;
      st = execute(q, w);
      e.status = st;
      e.written_value = (st == ST_OK) ? w : 0;
      e.acc_value = acc;
      e.gp0_value = gpr[0];
      e.gp1_value = gpr[1];
      e.gp2_value = gpr[2];
      e.gp3_value = gpr[3];
      e.gp4_value = gpr[4];
      e.gp5_value = gpr[5];
      e.gp6_value = gpr[6];
      e.gp7_value = gpr[7];
      pending.push_back(e);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task check_result(rsp_payload_type r);
      rsp_payload_type e;
      if (pending.size() == 0) begin
         report("unexpected item", 0, 0);
         return;
      end
      e = pending.pop_front();
      if (r.status !== e.status) report("status", r.status, e.status);
      if (r.written_value !== e.written_value)
         report("written_value", r.written_value, e.written_value);
      if (r.acc_value !== e.acc_value) report("acc", r.acc_value, e.acc_value);
      if (r.gp0_value !== e.gp0_value) report("r0", r.gp0_value, e.gp0_value);
      if (r.gp1_value !== e.gp1_value) report("r1", r.gp1_value, e.gp1_value);
      if (r.gp2_value !== e.gp2_value) report("r2", r.gp2_value, e.gp2_value);
      if (r.gp3_value !== e.gp3_value) report("r3", r.gp3_value, e.gp3_value);
      if (r.gp4_value !== e.gp4_value) report("r4", r.gp4_value, e.gp4_value);
      if (r.gp5_value !== e.gp5_value) report("r5", r.gp5_value, e.gp5_value);
      if (r.gp6_value !== e.gp6_value) report("r6", r.gp6_value, e.gp6_value);
      if (r.gp7_value !== e.gp7_value) report("r7", r.gp7_value, e.gp7_value);
   endtask
endclass

module tb_toy_vm_instruction_executor;
   logic clock = 0;
   logic reset = 1;
   tvx_req_if req_chan ();
   tvx_rsp_if rsp_chan ();
   vm_scoreboard sb;
   longint cycles = 0;
   bit stim_done = 0;
   bit long_hold = 0;
   int shadow_depth = 0;

   localparam longint CYCLE_LIMIT = 2000000;
   localparam logic [7:0] ALL_OPS [16] = '{OP_MOV, OP_XCHG, OP_ADD, OP_SUB, OP_MUL,
      OP_DIV, OP_AND, OP_OR, OP_XOR, OP_PUSH, OP_POP, OP_INC, OP_DEC, OP_ABS,
      OP_NEG, OP_NOT};

   toy_vm_instruction_executor uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.payload = '0;
      rsp_chan.ready = 0;
      sb = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task send(logic [7:0] op, logic [7:0] am, logic [31:0] a, logic [31:0] b);
      req_payload_type q;
      q = '{op, am, a, b};
      req_chan.valid <= 1;
      req_chan.payload <= q;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_instruction(q);
      if (op == OP_PUSH && sb.pending[$].status == ST_OK) shadow_depth++;
      if (op == OP_POP && sb.pending[$].status == ST_OK) shadow_depth--;
      repeat (gap_len()) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
   endtask

   function logic [31:0] pick_operand(logic [3:0] m);
      case (m)
         MODE_REG, MODE_IND: return ($urandom_range(0, 19) == 0) ?
            $urandom_range(9, 100) : $urandom_range(0, NUM_REGS);
         MODE_DIR: return ($urandom_range(0, 7) == 0) ? $urandom() :
            $urandom_range(0, 63);
         default: case ($urandom_range(0, 4))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return SIGN_MASK;
            3: return $urandom_range(0, 15);
            default: return $urandom();
         endcase
      endcase
   endfunction

   task random_item();
      logic [7:0] op, am;
      logic [3:0] dm, sm;
      int k;
      k = $urandom_range(0, 99);
      if (k < 4) begin
         op = $urandom();
         am = $urandom();
      end else begin
         op = ALL_OPS[$urandom_range(0, 15)];
         dm = $urandom_range(0, 3);
         if (op == OP_PUSH || op == OP_POP || op == OP_INC || op == OP_DEC ||
             op == OP_ABS || op == OP_NEG || op == OP_NOT) sm = MODE_NONE;
         else sm = $urandom_range(0, 3);
         if (k < 8) sm = $urandom();
         am = {dm, sm};
      end
      // keep the stack moving between empty and full
      if (op == OP_POP && shadow_depth == 0 && $urandom_range(0, 3) != 0) op = OP_PUSH;
      send(op, am, pick_operand(am[7:4]), pick_operand(am[3:0]));
   endtask

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.payload);
   end

   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         hold = gap_len();
         rsp_chan.ready <= (hold == 0);
         if (hold != 0) repeat (hold - 1) @(posedge clock);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes, corner cases and most operations (not AND, OR, XOR or DEC)
      send(OP_MOV,  8'h01, 0, 32'hFFFF_FFFF);
      send(OP_MOV,  8'h01, 1, SIGN_MASK);
      send(OP_ABS,  8'h0F, 1, 0);
      send(OP_ABS,  8'h0F, 0, 0);
      send(OP_ABS,  8'h1F, 0, 5);
      send(OP_ABS,  8'h1F, 0, 32'hFFFF_FFF0);
      send(OP_MOV,  8'h21, 32'hFFFF_FFFE, 32'h1234_5678);
      send(OP_MOV,  8'h02, 2, 32'hFFFF_FFFE);
      send(OP_MOV,  8'h01, 3, 32'hFFFF_FFFE);
      send(OP_XCHG, 8'h30, 3, 3);
      send(OP_XCHG, 8'h23, 0, 1);
      send(OP_POP,  8'h0F, 1, 0);
      send(OP_PUSH, 8'h1F, 32'hDEAD_BEEF, 0);
      send(OP_POP,  8'h1F, 0, 0);
      send(OP_POP,  8'h3F, 2, 0);
      send(OP_DIV,  8'h01, 0, 0);
      send(OP_DIV,  8'h01, 0, 7);
      send(OP_MUL,  8'h01, 0, 32'hFFFF_FFFF);
      send(OP_ADD,  8'h09, 1, 9);
      send(8'h00,   8'h00, 0, 0);
      send(OP_INC,  8'h4F, 0, 0);
      send(OP_SUB,  8'h12, 0, 0);
      send(OP_NEG,  8'h0E, 0, 0);
      send(OP_NOT,  8'h0F, 2, 0);
      for (int i = 0; i < 17; i++) send(OP_PUSH, 8'h0F, i % 9, 0);
      long_hold = 1;
      for (int i = 0; i < 1400; i++) random_item();
      req_chan.valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
